/* design/piecewise_linear_interp_table_assert.svh */
// -----------------------------------------------------------------------------
// Assertion macros for the interpolation table
// Shared property shapes used by the RTL checks.
// -----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_INTERP_TABLE_ASSERT_SVH
`define PIECEWISE_LINEAR_INTERP_TABLE_ASSERT_SVH

// same-cycle implication
`define PLIT_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PLIT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/plit_pkg.sv */
// -----------------------------------------------------------------------------
// plit_pkg
// Widths, codes and shared types of the interpolation table.
// -----------------------------------------------------------------------------
package plit_pkg;

   localparam int IDX_W  = 5;
   localparam int KEY_W  = 16;
   localparam int VAL_W  = 32;
   localparam int CNT_W  = 6;
   localparam int PROD_W = VAL_W + KEY_W;

   localparam int MUL_STEPS = KEY_W;
   localparam int DIV_STEPS = VAL_W;
   localparam int STEP_W    = 5;

   typedef enum logic {
      REQ_WRITE = 1'b0,
      REQ_QUERY = 1'b1
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LAST,
      ST_LAST_CHK,
      ST_SCAN,
      ST_BLEND,
      ST_DONE
   } top_state_type;

   typedef enum logic [1:0] {
      BL_IDLE,
      BL_MUL,
      BL_DIV,
      BL_DONE
   } blend_state_type;

   typedef struct packed {
      logic [VAL_W-1:0] lo_val;
      logic [VAL_W-1:0] hi_val;
      logic [KEY_W-1:0] dx;
      logic [KEY_W-1:0] span;
   } blend_req_type;

   typedef struct packed {
      logic             done;
      logic [VAL_W-1:0] value;
   } blend_rsp_type;

endpackage

/* design/plit_if.sv */
// -----------------------------------------------------------------------------
// plit_req_if / plit_rsp_if
// Request and response channels, valid/ready handshake.
// -----------------------------------------------------------------------------
interface plit_req_if;
   logic                       valid;
   logic                       ready;
   logic                       req_type;
   logic [plit_pkg::IDX_W-1:0] point_index;
   logic [plit_pkg::KEY_W-1:0] point_key;
   logic [plit_pkg::VAL_W-1:0] point_value;
   logic [plit_pkg::KEY_W-1:0] query_x;

   modport source (output valid, req_type, point_index, point_key, point_value, query_x,
                   input ready);
   modport sink   (input valid, req_type, point_index, point_key, point_value, query_x,
                   output ready);
endinterface

interface plit_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [plit_pkg::VAL_W-1:0] result_value;
   logic                       in_range;
   logic                       exact_hit;

   modport source (output valid, result_value, in_range, exact_hit, input ready);
   modport sink   (input valid, result_value, in_range, exact_hit, output ready);
endinterface

/* design/piecewise_linear_interp_table.sv */
// -----------------------------------------------------------------------------
// piecewise_linear_interp_table
// A breakpoint write (req_type 0) stores one key/value word and returns
// nothing. A query (req_type 1) returns one word: it reads the last key in
// use, then scans the table from slot 0 one entry per cycle through the
// single memory read port. An empty table goes straight to the answer state,
// an abscissa above the last key is answered from the last-key check, a hit
// or an abscissa below the first key from the scan. Interpolation hands the
// bracket to the blend unit, which multiplies one bit per cycle (16 steps),
// divides one quotient bit per cycle (32 steps) and forms the sum in its done
// state. A full answer register holds the final step until it drains. The
// request side takes a new word while the previous answer waits in the output
// register. points_in_use is written through csr_write_enable/csr_write_data;
// the user must write it only while idle; the block does not enforce this.
// -----------------------------------------------------------------------------
`include "piecewise_linear_interp_table_assert.svh"

module piecewise_linear_interp_table #(
   parameter int MAX_POINTS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   plit_req_if.sink                    req,
   plit_rsp_if.source                  rsp,
   input  logic                        csr_write_enable,
   input  logic [plit_pkg::CNT_W-1:0]  csr_write_data
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = (AW > plit_pkg::CNT_W) ? AW : plit_pkg::CNT_W;

   plit_pkg::top_state_type     state_ff, state_in;
   logic [plit_pkg::CNT_W-1:0]  points_ff;
   logic [plit_pkg::KEY_W-1:0]  x_ff, x_in;
   logic [AW-1:0]               last_ff, last_in;
   logic [AW-1:0]               idx_ff, idx_in;
   logic [plit_pkg::KEY_W-1:0]  prev_key_ff, prev_key_in;
   logic [plit_pkg::VAL_W-1:0]  prev_val_ff, prev_val_in;
   logic [plit_pkg::VAL_W-1:0]  res_ff, res_in;
   logic                        inr_ff, inr_in;
   logic                        hit_ff, hit_in;
   logic                        rsp_valid_ff;
   logic [plit_pkg::VAL_W-1:0]  rsp_value_ff;
   logic                        rsp_inr_ff;
   logic                        rsp_hit_ff;

   logic                        accept;
   logic                        is_query;
   logic                        out_load;
   logic                        wr_en;
   logic [AW-1:0]               rd_addr;
   logic [plit_pkg::KEY_W-1:0]  rd_key;
   logic [plit_pkg::VAL_W-1:0]  rd_val;
   logic [CW-1:0]               points_ext;
   logic                        blend_start;
   plit_pkg::blend_req_type     blend_req;
   plit_pkg::blend_rsp_type     blend_rsp;

   assign accept     = req.valid && req.ready;
   assign is_query   = req.req_type == plit_pkg::REQ_QUERY;
   assign wr_en      = accept && !is_query && (32'(req.point_index) < MAX_POINTS);
   assign points_ext = CW'(points_ff);

   assign blend_req.lo_val = prev_val_ff;
   assign blend_req.hi_val = rd_val;
   assign blend_req.dx     = x_ff - prev_key_ff;
   assign blend_req.span   = rd_key - prev_key_ff;

   plit_table #(
      .MAX_POINTS (MAX_POINTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req.point_index)),
      .wr_key  (req.point_key),
      .wr_val  (req.point_value),
      .rd_addr (rd_addr),
      .rd_key  (rd_key),
      .rd_val  (rd_val)
   );

   plit_blend u_blend (
      .clock (clock),
      .reset (reset),
      .start (blend_start),
      .op    (blend_req),
      .res   (blend_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= plit_pkg::ST_IDLE;
         points_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            points_ff <= csr_write_data;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      x_ff        <= x_in;
      last_ff     <= last_in;
      idx_ff      <= idx_in;
      prev_key_ff <= prev_key_in;
      prev_val_ff <= prev_val_in;
      res_ff      <= res_in;
      inr_ff      <= inr_in;
      hit_ff      <= hit_in;
      if (out_load) begin
         rsp_value_ff <= res_ff;
         rsp_inr_ff   <= inr_ff;
         rsp_hit_ff   <= hit_ff;
      end
   end

   always_comb begin
      state_in    = state_ff;
      x_in        = x_ff;
      last_in     = last_ff;
      idx_in      = idx_ff;
      prev_key_in = prev_key_ff;
      prev_val_in = prev_val_ff;
      res_in      = res_ff;
      inr_in      = inr_ff;
      hit_in      = hit_ff;
      rd_addr     = idx_ff;
      blend_start = 1'b0;
      out_load    = 1'b0;
      req.ready   = 1'b0;
      unique case (state_ff)
         plit_pkg::ST_IDLE: begin
            req.ready = 1'b1;
            if (accept && is_query) begin
               x_in = req.query_x;
               if (32'(points_ff) >= MAX_POINTS) begin
                  last_in = AW'(MAX_POINTS - 1);
               end else begin
                  last_in = AW'(points_ext - CW'(1));
               end
               if (points_ff == '0) begin
                  res_in   = '0;
                  inr_in   = 1'b0;
                  hit_in   = 1'b0;
                  state_in = plit_pkg::ST_DONE;
               end else begin
                  state_in = plit_pkg::ST_LAST;
               end
            end
         end
         plit_pkg::ST_LAST: begin
            rd_addr  = last_ff;
            state_in = plit_pkg::ST_LAST_CHK;
         end
         plit_pkg::ST_LAST_CHK: begin
            rd_addr = '0;
            idx_in  = '0;
            if (rd_key < x_ff) begin
               res_in   = '0;
               inr_in   = 1'b0;
               hit_in   = 1'b0;
               state_in = plit_pkg::ST_DONE;
            end else begin
               state_in = plit_pkg::ST_SCAN;
            end
         end
         plit_pkg::ST_SCAN: begin
            rd_addr = idx_ff + AW'(1);
            if (rd_key >= x_ff) begin
               if (rd_key == x_ff) begin
                  res_in   = rd_val;
                  inr_in   = 1'b1;
                  hit_in   = 1'b1;
                  state_in = plit_pkg::ST_DONE;
               end else if (idx_ff == '0) begin
                  // below the first key
                  res_in   = '0;
                  inr_in   = 1'b0;
                  hit_in   = 1'b0;
                  state_in = plit_pkg::ST_DONE;
               end else begin
                  blend_start = 1'b1;
                  inr_in      = 1'b1;
                  hit_in      = 1'b0;
                  state_in    = plit_pkg::ST_BLEND;
               end
            end else begin
               prev_key_in = rd_key;
               prev_val_in = rd_val;
               idx_in      = idx_ff + AW'(1);
            end
         end
         plit_pkg::ST_BLEND: begin
            if (blend_rsp.done) begin
               res_in   = blend_rsp.value;
               state_in = plit_pkg::ST_DONE;
            end
         end
         plit_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               out_load = 1'b1;
               state_in = plit_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = plit_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.result_value = rsp_value_ff;
   assign rsp.in_range     = rsp_inr_ff;
   assign rsp.exact_hit    = rsp_hit_ff;

   `PLIT_ASSERT_NEXT(a_query_start, clock, reset, accept && is_query,
      state_ff == plit_pkg::ST_LAST || state_ff == plit_pkg::ST_DONE, "query did not start")
   `PLIT_ASSERT_IMPLY(a_scan_bound, clock, reset, state_ff == plit_pkg::ST_SCAN,
      idx_ff <= last_ff, "scan ran past last key")
   `PLIT_ASSERT_IMPLY(a_blend_owned, clock, reset, blend_rsp.done,
      state_ff == plit_pkg::ST_BLEND, "blend finished unexpectedly")
   `PLIT_ASSERT_IMPLY(a_hit_in_range, clock, reset, rsp_valid_ff && rsp_hit_ff,
      rsp_inr_ff, "hit outside range")
   `PLIT_ASSERT_IMPLY(a_out_zero, clock, reset, rsp_valid_ff && !rsp_inr_ff,
      rsp_value_ff == '0, "out of range word not zero")

endmodule

/* design/plit_table.sv */
// -----------------------------------------------------------------------------
// plit_table
// Breakpoint memory: one write port, one registered read port.
// -----------------------------------------------------------------------------
module plit_table #(
   parameter int MAX_POINTS = 32
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [$clog2(MAX_POINTS)-1:0]         wr_addr,
   input  logic [plit_pkg::KEY_W-1:0]            wr_key,
   input  logic [plit_pkg::VAL_W-1:0]            wr_val,
   input  logic [$clog2(MAX_POINTS)-1:0]         rd_addr,
   output logic [plit_pkg::KEY_W-1:0]            rd_key,
   output logic [plit_pkg::VAL_W-1:0]            rd_val
);

   logic [plit_pkg::KEY_W-1:0] key_mem_ff [MAX_POINTS];
   logic [plit_pkg::VAL_W-1:0] val_mem_ff [MAX_POINTS];
   logic [plit_pkg::KEY_W-1:0] rd_key_ff;
   logic [plit_pkg::VAL_W-1:0] rd_val_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem_ff[wr_addr] <= wr_key;
         val_mem_ff[wr_addr] <= wr_val;
      end
      rd_key_ff <= key_mem_ff[rd_addr];
      rd_val_ff <= val_mem_ff[rd_addr];
   end

   assign rd_key = rd_key_ff;
   assign rd_val = rd_val_ff;

endmodule

/* design/plit_blend.sv */
// -----------------------------------------------------------------------------
// plit_blend
// lo +/- (|hi-lo| * dx) / span, bit-serial multiply then restoring divide.
// -----------------------------------------------------------------------------
module plit_blend (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  plit_pkg::blend_req_type op,
   output plit_pkg::blend_rsp_type res
);

   plit_pkg::blend_state_type       state_ff, state_in;
   logic [plit_pkg::STEP_W-1:0]     cnt_ff, cnt_in;
   logic [plit_pkg::PROD_W-1:0]     acc_ff, acc_in;
   logic [plit_pkg::VAL_W-1:0]      diff_ff, diff_in;
   logic [plit_pkg::VAL_W-1:0]      lo_ff, lo_in;
   logic [plit_pkg::KEY_W-1:0]      dx_ff, dx_in;
   logic [plit_pkg::KEY_W-1:0]      span_ff, span_in;
   logic                            neg_ff, neg_in;
   logic [plit_pkg::KEY_W:0]        trial;
   logic                            ge;
   logic [plit_pkg::KEY_W:0]        rem;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= plit_pkg::BL_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff  <= cnt_in;
      acc_ff  <= acc_in;
      diff_ff <= diff_in;
      lo_ff   <= lo_in;
      dx_ff   <= dx_in;
      span_ff <= span_in;
      neg_ff  <= neg_in;
   end

   // one quotient bit: remainder stays below span
   assign trial = {acc_ff[plit_pkg::PROD_W-1:plit_pkg::VAL_W], acc_ff[plit_pkg::VAL_W-1]};
   assign ge    = trial >= {1'b0, span_ff};
   assign rem   = ge ? (trial - {1'b0, span_ff}) : trial;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      diff_in   = diff_ff;
      lo_in     = lo_ff;
      dx_in     = dx_ff;
      span_in   = span_ff;
      neg_in    = neg_ff;
      res.done  = 1'b0;
      res.value = neg_ff ? (lo_ff - acc_ff[plit_pkg::VAL_W-1:0])
                         : (lo_ff + acc_ff[plit_pkg::VAL_W-1:0]);
      unique case (state_ff)
         plit_pkg::BL_IDLE: begin
            if (start) begin
               neg_in   = op.hi_val < op.lo_val;
               diff_in  = (op.hi_val < op.lo_val) ? (op.lo_val - op.hi_val)
                                                  : (op.hi_val - op.lo_val);
               lo_in    = op.lo_val;
               dx_in    = op.dx;
               span_in  = op.span;
               acc_in   = '0;
               cnt_in   = '0;
               state_in = plit_pkg::BL_MUL;
            end
         end
         plit_pkg::BL_MUL: begin
            acc_in = {acc_ff[plit_pkg::PROD_W-2:0], 1'b0}
                   + (dx_ff[plit_pkg::KEY_W-1] ? plit_pkg::PROD_W'(diff_ff)
                                               : plit_pkg::PROD_W'(0));
            dx_in  = {dx_ff[plit_pkg::KEY_W-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == plit_pkg::STEP_W'(plit_pkg::MUL_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = plit_pkg::BL_DIV;
            end
         end
         plit_pkg::BL_DIV: begin
            acc_in = {rem[plit_pkg::KEY_W-1:0], acc_ff[plit_pkg::VAL_W-2:0], ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == plit_pkg::STEP_W'(plit_pkg::DIV_STEPS - 1)) begin
               state_in = plit_pkg::BL_DONE;
            end
         end
         plit_pkg::BL_DONE: begin
            res.done = 1'b1;
            state_in = plit_pkg::BL_IDLE;
         end
         default: begin
            state_in = plit_pkg::BL_IDLE;
         end
      endcase
   end

endmodule

/* tb/sv/piecewise_linear_interp_table_tb.sv */
// -----------------------------------------------------------------------------
// piecewise_linear_interp_table_tb
// Drives breakpoint writes and queries into the interpolation table, predicts
// every answer word from a shadow copy of the table and the point count, and
// checks each answer field by field. Both channels idle at random, the answer
// side holds off for long stretches and the point count is changed while idle.
// -----------------------------------------------------------------------------
module piecewise_linear_interp_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH   = 32;
   localparam int SETTLE_CYCLES = 150;
   localparam int TAIL_CYCLES   = 150;
   localparam int LONG_HOLD     = 400;

   typedef enum logic [1:0] {
      STEP_WORD,
      STEP_CSR,
      STEP_PAUSE
   } step_op_type;

   typedef struct {
      step_op_type                  op;
      plit_pkg::req_kind_type       kind;
      logic [plit_pkg::IDX_W-1:0]   idx;
      logic [plit_pkg::KEY_W-1:0]   key;
      logic [plit_pkg::VAL_W-1:0]   value;
      logic [plit_pkg::KEY_W-1:0]   qx;
      logic [plit_pkg::CNT_W-1:0]   count;
      int                           cycles;
   } stim_step_type;

   typedef struct packed {
      logic [plit_pkg::VAL_W-1:0] value;
      logic                       in_range;
      logic                       hit;
   } interp_word_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [plit_pkg::CNT_W-1:0] csr_write_data;

   plit_req_if req_ch ();
   plit_rsp_if rsp_ch ();

   piecewise_linear_interp_table #(
      .MAX_POINTS(TABLE_DEPTH)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   stim_step_type              stim_steps[$];
   interp_word_type            pending_answers[$];
   logic [plit_pkg::KEY_W-1:0] key_tbl[TABLE_DEPTH];
   logic [plit_pkg::VAL_W-1:0] val_tbl[TABLE_DEPTH];
   logic [plit_pkg::CNT_W-1:0] pts_cfg;
   logic [plit_pkg::KEY_W-1:0] gen_keys[TABLE_DEPTH];
   bit                         sender_calm;
   bit                         req_taken;
   bit                         rsp_taken;
   int                         answers_seen;
   int                         mismatch_count;
   int                         hold_left;

   function automatic interp_word_type interpolate(input logic [plit_pkg::KEY_W-1:0] x);
      interp_word_type            w;
      int                         n;
      int                         i;
      logic [plit_pkg::VAL_W-1:0] lo;
      logic [plit_pkg::VAL_W-1:0] hi;
      logic [63:0]                diff;
      logic [63:0]                dx;
      logic [63:0]                span;
      logic [63:0]                part;
      w = '0;
      n = (pts_cfg > TABLE_DEPTH) ? TABLE_DEPTH : int'(pts_cfg);
      if (n > 0 && x >= key_tbl[0] && x <= key_tbl[n - 1]) begin
         w.in_range = 1'b1;
         i = 0;
         while (i < n - 1 && key_tbl[i] < x)
            i++;
         if (key_tbl[i] == x || i == 0) begin
            w.hit   = (key_tbl[i] == x);
            w.value = val_tbl[i];
         end else begin
            lo   = val_tbl[i - 1];
            hi   = val_tbl[i];
            dx   = 64'(x - key_tbl[i - 1]);
            span = 64'(key_tbl[i] - key_tbl[i - 1]);
            if (hi >= lo) begin
               diff    = 64'(hi - lo);
               part    = (diff * dx) / span;
               w.value = lo + part[plit_pkg::VAL_W-1:0];
            end else begin
               diff    = 64'(lo - hi);
               part    = (diff * dx) / span;
               w.value = lo - part[plit_pkg::VAL_W-1:0];
            end
         end
      end
      return w;
   endfunction

   function automatic logic [plit_pkg::VAL_W-1:0] rnd_value();
      int r;
      r = $urandom_range(0, 7);
      if (r == 0)
         return '0;
      if (r == 1)
         return '1;
      return plit_pkg::VAL_W'($urandom);
   endfunction

   task automatic add_word(input plit_pkg::req_kind_type kind,
                           input logic [plit_pkg::IDX_W-1:0] idx,
                           input logic [plit_pkg::KEY_W-1:0] key,
                           input logic [plit_pkg::VAL_W-1:0] value,
                           input logic [plit_pkg::KEY_W-1:0] qx);
      stim_step_type s;
      s        = '{op: STEP_WORD, kind: plit_pkg::REQ_WRITE, default: '0};
      s.kind   = kind;
      s.idx    = idx;
      s.key    = key;
      s.value  = value;
      s.qx     = qx;
      s.cycles = sender_calm ? 0 : $urandom_range(0, 7);
      stim_steps.push_back(s);
   endtask

   task automatic add_write(input logic [plit_pkg::IDX_W-1:0] idx,
                            input logic [plit_pkg::KEY_W-1:0] key,
                            input logic [plit_pkg::VAL_W-1:0] value);
      gen_keys[idx] = key;
      add_word(plit_pkg::REQ_WRITE, idx, key, value, plit_pkg::KEY_W'($urandom));
   endtask

   task automatic add_query(input logic [plit_pkg::KEY_W-1:0] x);
      add_word(plit_pkg::REQ_QUERY, plit_pkg::IDX_W'($urandom), plit_pkg::KEY_W'($urandom),
               plit_pkg::VAL_W'($urandom), x);
   endtask

   task automatic add_pause(input int cycles);
      stim_step_type s;
      s        = '{op: STEP_PAUSE, kind: plit_pkg::REQ_WRITE, default: '0};
      s.cycles = cycles;
      stim_steps.push_back(s);
   endtask

   task automatic add_csr(input logic [plit_pkg::CNT_W-1:0] count);
      stim_step_type s;
      s       = '{op: STEP_CSR, kind: plit_pkg::REQ_WRITE, default: '0};
      s.count = count;
      stim_steps.push_back(s);
   endtask

   // ascending keys, now and then a repeated key or a last key at full scale
   task automatic build_table(input int n);
      int k;
      int stride;
      k = $urandom_range(0, 65535 - 64 * n);
      if ($urandom_range(0, 3) == 0)
         k = 0;
      stride = (65535 - k) / n;
      for (int s = 0; s < n; s++) begin
         if (s > 0 && $urandom_range(0, 15) != 0)
            k = k + $urandom_range(1, stride);
         if (s == n - 1 && $urandom_range(0, 3) == 0)
            k = 65535;
         add_write(plit_pkg::IDX_W'(s), plit_pkg::KEY_W'(k), rnd_value());
      end
   endtask

   task automatic run_phase(input int n_cfg, input int words);
      int                         n_eff;
      int                         r;
      int                         lo_k;
      int                         hi_k;
      logic [plit_pkg::KEY_W-1:0] x;
      n_eff = (n_cfg > TABLE_DEPTH) ? TABLE_DEPTH : n_cfg;
      add_pause(SETTLE_CYCLES);
      add_csr(plit_pkg::CNT_W'(n_cfg));
      sender_calm = ($urandom_range(0, 2) == 0);
      if (n_eff > 0)
         build_table(n_eff);
      for (int w = 0; w < words; w++) begin
         if (w == words / 2 && n_eff > 0 && $urandom_range(0, 1) == 1)
            build_table(n_eff);
         r = $urandom_range(0, 99);
         if (r < 6) begin
            add_write(plit_pkg::IDX_W'($urandom), plit_pkg::KEY_W'($urandom), rnd_value());
         end else if (r < 8) begin
            add_pause(0);
         end else begin
            if (n_eff == 0 || r < 18) begin
               x = plit_pkg::KEY_W'($urandom);
            end else begin
               lo_k = gen_keys[0];
               hi_k = gen_keys[n_eff - 1];
               if (r < 26)
                  x = ($urandom_range(0, 1) == 1) ? plit_pkg::KEY_W'(lo_k - 1)
                                                  : plit_pkg::KEY_W'(hi_k + 1);
               else if (r < 45)
                  x = gen_keys[$urandom_range(0, n_eff - 1)];
               else
                  x = plit_pkg::KEY_W'($urandom_range(lo_k, hi_k));
            end
            add_query(x);
         end
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // request driver
   always @(negedge clock) begin : drive_requests
      logic v_nxt;
      logic we_nxt;
      v_nxt  = 1'b0;
      we_nxt = 1'b0;
      if (!reset) begin
         if (req_ch.valid && !req_taken) begin
            v_nxt = 1'b1;
         end else if (stim_steps.size() != 0) begin
            case (stim_steps[0].op)
               STEP_WORD: begin
                  if (stim_steps[0].cycles > 0) begin
                     stim_steps[0].cycles = stim_steps[0].cycles - 1;
                  end else begin
                     req_ch.req_type    <= stim_steps[0].kind;
                     req_ch.point_index <= stim_steps[0].idx;
                     req_ch.point_key   <= stim_steps[0].key;
                     req_ch.point_value <= stim_steps[0].value;
                     req_ch.query_x     <= stim_steps[0].qx;
                     v_nxt = 1'b1;
                     void'(stim_steps.pop_front());
                  end
               end
               STEP_PAUSE: begin
                  if (pending_answers.size() == 0) begin
                     if (stim_steps[0].cycles > 0)
                        stim_steps[0].cycles = stim_steps[0].cycles - 1;
                     else
                        void'(stim_steps.pop_front());
                  end
               end
               STEP_CSR: begin
                  we_nxt = 1'b1;
                  csr_write_data <= stim_steps[0].count;
                  pts_cfg = stim_steps[0].count;
                  void'(stim_steps.pop_front());
               end
               default: ;
            endcase
         end
      end
      req_ch.valid     <= v_nxt;
      csr_write_enable <= we_nxt;
   end

   // answer side back-pressure
   always @(negedge clock) begin : drive_ready
      if (!reset) begin
         if (rsp_taken) begin
            if (answers_seen == 30 || answers_seen == 200)
               hold_left = LONG_HOLD;
            else if ((answers_seen / 40) % 3 == 2)
               hold_left = 0;
            else
               hold_left = $urandom_range(0, 7);
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left = hold_left - 1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // monitor: answers checked first, then the accepted request word
   always @(posedge clock) begin : observe
      interp_word_type want;
      if (reset) begin
         req_taken = 1'b0;
         rsp_taken = 1'b0;
      end else begin
         rsp_taken = rsp_ch.valid && rsp_ch.ready;
         if (rsp_taken) begin
            answers_seen++;
            if (pending_answers.size() == 0) begin
               $display("%0t: answer word with none expected, got value %h range %b hit %b",
                        $time, rsp_ch.result_value, rsp_ch.in_range, rsp_ch.exact_hit);
               mismatch_count++;
            end else begin
               want = pending_answers.pop_front();
               if (rsp_ch.result_value !== want.value) begin
                  $display("%0t: result_value expected %h, got %h",
                           $time, want.value, rsp_ch.result_value);
                  mismatch_count++;
               end
               if (rsp_ch.in_range !== want.in_range) begin
                  $display("%0t: in_range expected %b, got %b",
                           $time, want.in_range, rsp_ch.in_range);
                  mismatch_count++;
               end
               if (rsp_ch.exact_hit !== want.hit) begin
                  $display("%0t: exact_hit expected %b, got %b",
                           $time, want.hit, rsp_ch.exact_hit);
                  mismatch_count++;
               end
            end
         end
         req_taken = req_ch.valid && req_ch.ready;
         if (req_taken) begin
            if (req_ch.req_type == plit_pkg::REQ_WRITE) begin
               key_tbl[req_ch.point_index] = req_ch.point_key;
               val_tbl[req_ch.point_index] = req_ch.point_value;
            end else begin
               pending_answers.push_back(interpolate(req_ch.query_x));
            end
         end
      end
   end

   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.req_type    = plit_pkg::REQ_WRITE;
      req_ch.point_index = '0;
      req_ch.point_key   = '0;
      req_ch.point_value = '0;
      req_ch.query_x     = '0;
      rsp_ch.ready       = 1'b0;
      csr_write_enable   = 1'b0;
      csr_write_data     = '0;
      pts_cfg            = '0;
      sender_calm        = 1'b0;
      req_taken          = 1'b0;
      rsp_taken          = 1'b0;
      answers_seen       = 0;
      mismatch_count     = 0;
      hold_left          = 0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         key_tbl[i]  = '0;
         val_tbl[i]  = '0;
         gen_keys[i] = '0;
      end

      // directed: four points, edges, both slopes, equal and unordered keys
      add_csr(plit_pkg::CNT_W'(4));
      add_write(plit_pkg::IDX_W'(0), 16'h0010, 32'h0000_0000);
      add_write(plit_pkg::IDX_W'(1), 16'h0100, 32'hFFFF_FFFF);
      add_write(plit_pkg::IDX_W'(2), 16'h0180, 32'h1234_5678);
      add_write(plit_pkg::IDX_W'(3), 16'hFFFF, 32'h8000_0001);
      add_query(16'h0000);
      add_query(16'h0010);
      add_query(16'h0088);
      add_query(16'h0140);
      add_query(16'h01FF);
      add_query(16'hFFFF);
      add_write(plit_pkg::IDX_W'(3), 16'hFFF0, 32'hFFFF_FFFF);
      add_query(16'hFFFF);
      add_write(plit_pkg::IDX_W'(0), 16'h0000, 32'hFFFF_FFFF);
      add_write(plit_pkg::IDX_W'(1), 16'h0000, 32'h0000_0000);
      add_query(16'h0000);
      add_query(16'h0001);
      add_write(plit_pkg::IDX_W'(1), 16'h0200, 32'h0000_0000);
      add_query(16'h0190);
      add_query(16'h1000);

      run_phase(32, 20);
      run_phase(0, 10);
      run_phase(63, 20);
      run_phase(1, 15);
      run_phase(2, 20);
      run_phase(33, 20);
      run_phase(7, 25);
      run_phase(16, 20);
      run_phase(3, 25);
      run_phase(32, 20);
      run_phase(20, 20);
      run_phase(63, 20);

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      while (stim_steps.size() != 0 || req_ch.valid || pending_answers.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
